// ===== rtl/core/dda_pkg.sv =====
package dda_pkg;

	// Geometry and fixed-point format
	localparam int COORD_BITS  = 11;
	localparam int MAX_PIXELS  = 64;
	localparam int FRAC_BITS   = 16;
	localparam int COLOR_BITS  = 32;

	// Derived widths
	localparam int SQ_BITS     = 2 * COORD_BITS + 1;
	localparam int SQRT_STEPS  = (SQ_BITS + 1) / 2;
	localparam int N_BITS      = SQRT_STEPS;
	localparam int DIV_BITS    = COORD_BITS + FRAC_BITS;
	localparam int STEP_BITS   = FRAC_BITS + 2;
	localparam int POS_BITS    = COORD_BITS + FRAC_BITS + 1;
	localparam int CNT_BITS    = $clog2(MAX_PIXELS + 1);
	localparam int ITER_BITS   = $clog2(DIV_BITS);

	// Segment queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		F_IDLE,
		F_SQUARE,
		F_ROOT,
		F_DIVIDE,
		F_PUSH
	} front_state_t;

	typedef enum logic {
		B_IDLE,
		B_RUN
	} back_state_t;

	// One classified segment ready to be walked
	typedef struct packed {
		logic [COORD_BITS-1:0]       x0;
		logic [COORD_BITS-1:0]       y0;
		logic signed [STEP_BITS-1:0] step_x;
		logic signed [STEP_BITS-1:0] step_y;
		logic [CNT_BITS-1:0]         emit;
		logic                        clipped;
	} seg_t;

	// Queue handshake toward the front end
	typedef struct packed {
		logic push;
		logic full;
	} qwr_t;

	// Queue handshake toward the back end
	typedef struct packed {
		logic pop;
		logic avail;
	} qrd_t;

endpackage

// ===== rtl/core/dda_front.sv =====
module dda_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [dda_pkg::COORD_BITS-1:0] start_x,
	input  logic [dda_pkg::COORD_BITS-1:0] start_y,
	input  logic [dda_pkg::COORD_BITS-1:0] end_x,
	input  logic [dda_pkg::COORD_BITS-1:0] end_y,
	input  logic                           q_full,
	output logic                           q_push,
	output dda_pkg::seg_t                  q_entry
);
	import dda_pkg::*;

	front_state_t state_q, state_d;

	logic [COORD_BITS-1:0] x0_q, y0_q, adx_q, ady_q;
	logic                  sx_neg_q, sy_neg_q;
	logic [SQ_BITS-1:0]    v_q, root_q, bit_q;
	logic [ITER_BITS-1:0]  iter_q;
	logic [N_BITS-1:0]     n_q;
	logic [N_BITS-1:0]     remx_q, remy_q;
	logic [DIV_BITS-1:0]   dvx_q, dvy_q;

	logic                  accept;
	logic [2*COORD_BITS-1:0] prod_x, prod_y;
	logic [SQ_BITS:0]      root_sum;
	logic                  root_ge;
	logic [SQ_BITS-1:0]    v_nxt, root_nxt;
	logic [N_BITS:0]       remx_sh, remy_sh;
	logic                  gex, gey;
	logic [N_BITS-1:0]     remx_nxt, remy_nxt;
	logic [STEP_BITS-1:0]  magx, magy;
	logic                  clipped;

	assign accept = in_valid && !in_stall;

	// Squares of the deltas
	assign prod_x = adx_q * adx_q;
	assign prod_y = ady_q * ady_q;

	// One step of the digit-pair square root
	assign root_sum = {1'b0, root_q} + {1'b0, bit_q};
	assign root_ge  = {1'b0, v_q} >= root_sum;
	assign v_nxt    = root_ge ? v_q - root_sum[SQ_BITS-1:0] : v_q;
	assign root_nxt = root_ge ? (root_q >> 1) + bit_q : root_q >> 1;

	// One restoring division step per lane
	assign remx_sh  = {remx_q, dvx_q[DIV_BITS-1]};
	assign remy_sh  = {remy_q, dvy_q[DIV_BITS-1]};
	assign gex      = remx_sh >= {1'b0, n_q};
	assign gey      = remy_sh >= {1'b0, n_q};
	assign remx_nxt = gex ? N_BITS'(remx_sh - {1'b0, n_q}) : N_BITS'(remx_sh);
	assign remy_nxt = gey ? N_BITS'(remy_sh - {1'b0, n_q}) : N_BITS'(remy_sh);

	// Signed steps and pixel count for the queue
	assign magx    = STEP_BITS'({1'b0, dvx_q[FRAC_BITS:0]});
	assign magy    = STEP_BITS'({1'b0, dvy_q[FRAC_BITS:0]});
	assign clipped = 32'(n_q) > 32'(MAX_PIXELS);

	always_comb begin
		q_entry.x0      = x0_q;
		q_entry.y0      = y0_q;
		q_entry.step_x  = sx_neg_q ? STEP_BITS'(0) - magx : magx;
		q_entry.step_y  = sy_neg_q ? STEP_BITS'(0) - magy : magy;
		q_entry.emit    = clipped ? CNT_BITS'(MAX_PIXELS) : CNT_BITS'(n_q);
		q_entry.clipped = clipped;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		q_push   = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_d = F_SQUARE;
			end
			F_SQUARE: begin
				state_d = F_ROOT;
			end
			F_ROOT: begin
				if (iter_q == '0) begin
					// zero-length segment produces nothing
					if (root_nxt[N_BITS-1:0] == '0) state_d = F_IDLE;
					else state_d = F_DIVIDE;
				end
			end
			F_DIVIDE: begin
				if (iter_q == '0) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full) begin
					q_push  = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x0_q     <= start_x;
			y0_q     <= start_y;
			sx_neg_q <= end_x < start_x;
			sy_neg_q <= end_y < start_y;
			adx_q    <= (end_x < start_x) ? start_x - end_x : end_x - start_x;
			ady_q    <= (end_y < start_y) ? start_y - end_y : end_y - start_y;
		end
		unique case (state_q)
			F_SQUARE: begin
				v_q    <= SQ_BITS'({1'b0, prod_x} + {1'b0, prod_y});
				root_q <= '0;
				bit_q  <= SQ_BITS'(1) << (2 * (SQRT_STEPS - 1));
				iter_q <= ITER_BITS'(SQRT_STEPS - 1);
			end
			F_ROOT: begin
				v_q    <= v_nxt;
				root_q <= root_nxt;
				bit_q  <= bit_q >> 2;
				iter_q <= iter_q - 1'b1;
				if (iter_q == '0) begin
					n_q    <= root_nxt[N_BITS-1:0];
					remx_q <= '0;
					remy_q <= '0;
					dvx_q  <= {adx_q, FRAC_BITS'(0)};
					dvy_q  <= {ady_q, FRAC_BITS'(0)};
					iter_q <= ITER_BITS'(DIV_BITS - 1);
				end
			end
			F_DIVIDE: begin
				remx_q <= remx_nxt;
				remy_q <= remy_nxt;
				dvx_q  <= {dvx_q[DIV_BITS-2:0], gex};
				dvy_q  <= {dvy_q[DIV_BITS-2:0], gey};
				iter_q <= iter_q - 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/dda_queue.sv =====
module dda_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dda_pkg::seg_t wr_entry,
	output logic          full,
	input  logic          pop,
	output logic          avail,
	output dda_pkg::seg_t rd_entry
);
	import dda_pkg::*;

	seg_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	assign full     = count_q == QCNT_BITS'(QUEUE_DEPTH);
	assign avail    = count_q != '0;
	assign rd_entry = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_entry;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> avail) else $error("queue pop while empty");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow push");

endmodule

// ===== rtl/core/dda_back.sv =====
module dda_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_avail,
	output logic                             q_pop,
	input  dda_pkg::seg_t                    q_entry,
	input  logic [dda_pkg::COLOR_BITS-1:0]   line_color,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [dda_pkg::COORD_BITS-1:0]   pixel_x,
	output logic [dda_pkg::COORD_BITS-1:0]   pixel_y,
	output logic [dda_pkg::COLOR_BITS-1:0]   pixel_color,
	output logic                             last_pixel,
	output logic                             count_clipped
);
	import dda_pkg::*;

	back_state_t state_q, state_d;

	logic signed [POS_BITS-1:0]  px_q, py_q;
	logic signed [STEP_BITS-1:0] sx_q, sy_q;
	logic [CNT_BITS-1:0]         left_q;
	logic                        clip_q;
	logic                        out_valid_q;
	logic [COORD_BITS-1:0]       pix_x_q, pix_y_q;
	logic [COLOR_BITS-1:0]       color_q;
	logic                        last_q, clipped_q;

	logic                        gen;
	logic [COORD_BITS-1:0]       cur_x, cur_y;

	assign out_valid     = out_valid_q;
	assign pixel_x       = pix_x_q;
	assign pixel_y       = pix_y_q;
	assign pixel_color   = color_q;
	assign last_pixel    = last_q;
	assign count_clipped = clipped_q;

	// Integer part of the current position, clamped at zero
	assign cur_x = px_q[POS_BITS-1] ? '0 : px_q[POS_BITS-2:FRAC_BITS];
	assign cur_y = py_q[POS_BITS-1] ? '0 : py_q[POS_BITS-2:FRAC_BITS];

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: fetch a segment, then walk it one pixel a cycle while out_stall does not hold it
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		gen     = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (q_avail) begin
					q_pop   = 1'b1;
					state_d = B_RUN;
				end
			end
			B_RUN: begin
				if (!out_valid_q || !out_stall) begin
					gen = 1'b1;
					if (left_q == CNT_BITS'(1)) state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= gen || (out_valid_q && out_stall);
		end
	end

	// Walker and output payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			px_q   <= {1'b0, q_entry.x0, FRAC_BITS'(0)};
			py_q   <= {1'b0, q_entry.y0, FRAC_BITS'(0)};
			sx_q   <= q_entry.step_x;
			sy_q   <= q_entry.step_y;
			left_q <= q_entry.emit;
			clip_q <= q_entry.clipped;
		end
		if (gen) begin
			pix_x_q   <= cur_x;
			pix_y_q   <= cur_y;
			color_q   <= line_color;
			last_q    <= left_q == CNT_BITS'(1);
			clipped_q <= clip_q;
			px_q      <= px_q + POS_BITS'(sx_q);
			py_q      <= py_q + POS_BITS'(sy_q);
			left_q    <= left_q - 1'b1;
		end
	end

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q && $stable(pix_x_q) && $stable(last_q))
		else $error("stalled pixel changed");
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(gen && left_q == CNT_BITS'(1)) |=> state_q == B_IDLE)
		else $error("walker kept running after last pixel");
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RUN) |-> left_q != '0) else $error("walker running with no pixels left");

endmodule

// ===== rtl/core/dda_line_rasterizer.sv =====
// Flow: after a segment is accepted, the front end squares the deltas, runs 12 bit-pair root
// steps and divides for both steps with the lanes in parallel, then pushes into the queue;
// the back end pops the segment and registers each pixel.
// Rate: the front end takes a new segment only once it is idle again (a zero-length one goes
// idle after the root), and the back end walks one pixel a cycle unless out_stall holds it.
// Reset: arst_n clears all control state and line_color to 0; no clearing pass is needed.
module dda_line_rasterizer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dda_pkg::COLOR_BITS-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [dda_pkg::COORD_BITS-1:0]  start_x,
	input  logic [dda_pkg::COORD_BITS-1:0]  start_y,
	input  logic [dda_pkg::COORD_BITS-1:0]  end_x,
	input  logic [dda_pkg::COORD_BITS-1:0]  end_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [dda_pkg::COORD_BITS-1:0]  pixel_x,
	output logic [dda_pkg::COORD_BITS-1:0]  pixel_y,
	output logic [dda_pkg::COLOR_BITS-1:0]  pixel_color,
	output logic                            last_pixel,
	output logic                            count_clipped
);
	import dda_pkg::*;

	logic [COLOR_BITS-1:0] line_color_q;
	qwr_t                  qwr;
	qrd_t                  qrd;
	seg_t                  wr_entry, rd_entry;

	// Color register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_color_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			line_color_q <= cfg_data;
		end
	end

	dda_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.start_x  (start_x),
		.start_y  (start_y),
		.end_x    (end_x),
		.end_y    (end_y),
		.q_full   (qwr.full),
		.q_push   (qwr.push),
		.q_entry  (wr_entry)
	);

	dda_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (qwr.push),
		.wr_entry (wr_entry),
		.full     (qwr.full),
		.pop      (qrd.pop),
		.avail    (qrd.avail),
		.rd_entry (rd_entry)
	);

	dda_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_avail       (qrd.avail),
		.q_pop         (qrd.pop),
		.q_entry       (rd_entry),
		.line_color    (line_color_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_color   (pixel_color),
		.last_pixel    (last_pixel),
		.count_clipped (count_clipped)
	);

endmodule

// ===== tb/tb_dda_line_rasterizer.sv =====
module tb_dda_line_rasterizer;
	timeunit 1ns;
	timeprecision 1ps;

	import dda_pkg::*;

	localparam int COORD_MAX        = (1 << COORD_BITS) - 1;
	localparam int RANDOM_PER_PHASE = 97;
	localparam int NUM_PHASES       = 4;
	localparam int SETTLE_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT   = 3000;
	localparam int MAX_REPORTS      = 30;

	// Expected pixel stream, built from each accepted segment
	class pixel_scoreboard;
		typedef struct {
			bit [COORD_BITS-1:0] x;
			bit [COORD_BITS-1:0] y;
			bit [COLOR_BITS-1:0] color;
			bit                  last;
			bit                  clipped;
		} pixel_t;

		pixel_t              expected_pixels[$];
		bit [COLOR_BITS-1:0] line_color;
		int                  errors;
		int                  segments;
		int                  empty_segments;
		int                  clipped_segments;
		int                  pixels_checked;

		function new();
			line_color = '0;
		endfunction

		// floor of a Q position, clamped at zero
		static function bit [COORD_BITS-1:0] to_pixel(longint pos);
			if (pos < 0)
				return '0;
			return COORD_BITS'(pos >> FRAC_BITS);
		endfunction

		function void note_segment(logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy,
				logic [COORD_BITS-1:0] ex, logic [COORD_BITS-1:0] ey);
			longint dx, dy, len_sq, len, trial, step_x, step_y, pos_x, pos_y;
			longint unit;
			int     emit;
			bit     clipped;
			pixel_t p;
			unit   = longint'(1) << FRAC_BITS;
			dx     = longint'(ex) - longint'(sx);
			dy     = longint'(ey) - longint'(sy);
			len_sq = dx * dx + dy * dy;
			// pixel count: floor of the exact length
			len = 0;
			for (int b = 15; b >= 0; b--) begin
				trial = len | (longint'(1) << b);
				if (trial * trial <= len_sq)
					len = trial;
			end
			segments++;
			if (len == 0) begin
				empty_segments++;
				return;
			end
			clipped = len > MAX_PIXELS;
			emit    = clipped ? MAX_PIXELS : int'(len);
			if (clipped)
				clipped_segments++;
			// steps truncate toward zero
			step_x = (dx * unit) / len;
			step_y = (dy * unit) / len;
			pos_x  = longint'(sx) * unit;
			pos_y  = longint'(sy) * unit;
			for (int k = 0; k < emit; k++) begin
				p.x       = to_pixel(pos_x);
				p.y       = to_pixel(pos_y);
				p.color   = line_color;
				p.last    = (k == emit - 1);
				p.clipped = clipped;
				expected_pixels.push_back(p);
				pos_x += step_x;
				pos_y += step_y;
			end
		endfunction

		function void check_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
				logic [COLOR_BITS-1:0] color, logic last, logic clipped);
			pixel_t p;
			if (expected_pixels.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b clip=%b",
						$time, x, y, color, last, clipped);
				return;
			end
			p = expected_pixels.pop_front();
			pixels_checked++;
			if (x !== p.x || y !== p.y || color !== p.color || last !== p.last ||
					clipped !== p.clipped) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: pixel mismatch: expected x=%0d y=%0d color=%h last=%b clip=%b,",
						$time, p.x, p.y, p.color, p.last, p.clipped,
						" actual x=%0d y=%0d color=%h last=%b clip=%b",
						x, y, color, last, clipped);
			end
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [COLOR_BITS-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic [COORD_BITS-1:0] start_x   = '0;
	logic [COORD_BITS-1:0] start_y   = '0;
	logic [COORD_BITS-1:0] end_x     = '0;
	logic [COORD_BITS-1:0] end_y     = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic [COLOR_BITS-1:0] pixel_color;
	logic                  last_pixel;
	logic                  count_clipped;

	pixel_scoreboard sb;
	bit              idle_on = 1'b1;

	dda_line_rasterizer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.start_x       (start_x),
		.start_y       (start_y),
		.end_x         (end_x),
		.end_y         (end_y),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_color   (pixel_color),
		.last_pixel    (last_pixel),
		.count_clipped (count_clipped)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Random back-pressure on the pixel output
	always @(negedge clk) begin
		out_stall <= idle_on && ($urandom_range(99) < 9);
	end

	// Transaction monitor: segments, pixels and color writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_segment(start_x, start_y, end_x, end_y);
			if (out_valid && !out_stall)
				sb.check_pixel(pixel_x, pixel_y, pixel_color, last_pixel, count_clipped);
			if (cfg_valid && cfg_ready)
				sb.line_color = cfg_data;
		end
	end

	// Watchdog: too long without any transaction
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("dda_line_rasterizer test failed");
		$finish;
	end

	// All driver tasks start and end at a falling edge
	task automatic write_line_color(input logic [COLOR_BITS-1:0] color);
		cfg_data  <= color;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_segment(input logic [COORD_BITS-1:0] sx, input logic [COORD_BITS-1:0] sy,
			input logic [COORD_BITS-1:0] ex, input logic [COORD_BITS-1:0] ey);
		while (idle_on && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		start_x  <= sx;
		start_y  <= sy;
		end_x    <= ex;
		end_y    <= ey;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Directed segment given as plain integers
	task automatic send_directed(input int sx, input int sy, input int ex, input int ey);
		send_segment(COORD_BITS'(sx), COORD_BITS'(sy), COORD_BITS'(ex), COORD_BITS'(ey));
	endtask

	function automatic logic [COORD_BITS-1:0] near(input logic [COORD_BITS-1:0] base,
			input int reach);
		int v;
		v = int'(base) + int'($urandom_range(2 * reach)) - reach;
		if (v < 0)
			v = 0;
		if (v > COORD_MAX)
			v = COORD_MAX;
		return COORD_BITS'(v);
	endfunction

	// Mix: empty, full-range (mostly saturated), very short, and medium segments
	task automatic send_random_segment();
		logic [COORD_BITS-1:0] sx, sy, ex, ey;
		int                    kind;
		sx   = COORD_BITS'($urandom);
		sy   = COORD_BITS'($urandom);
		kind = $urandom_range(99);
		if (kind < 5) begin
			ex = sx;
			ey = sy;
		end else if (kind < 25) begin
			ex = COORD_BITS'($urandom);
			ey = COORD_BITS'($urandom);
		end else if (kind < 45) begin
			ex = near(sx, 3);
			ey = near(sy, 3);
		end else begin
			ex = near(sx, 70);
			ey = near(sy, 70);
		end
		send_segment(sx, sy, ex, ey);
	endtask

	task automatic run_directed();
		// zero length at both corners
		send_directed(0, 0, 0, 0);
		send_directed(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		// single pixel in each direction, and a unit diagonal
		send_directed(5, 5, 6, 5);
		send_directed(6, 5, 5, 5);
		send_directed(5, 5, 6, 6);
		// exactly the pixel limit, then one past it
		send_directed(100, 100, 100, 164);
		send_directed(100, 164, 100, 100);
		send_directed(100, 100, 165, 100);
		send_directed(0, 0, 45, 45);
		send_directed(0, 0, 46, 46);
		// full-range diagonals and edges
		send_directed(0, 0, COORD_MAX, COORD_MAX);
		send_directed(COORD_MAX, COORD_MAX, 0, 0);
		send_directed(0, COORD_MAX, COORD_MAX, 0);
		send_directed(COORD_MAX, 0, 0, COORD_MAX);
		send_directed(0, 0, COORD_MAX, 0);
		send_directed(0, 0, 0, COORD_MAX);
		// exact and non-integer lengths, mixed step signs
		send_directed(10, 10, 13, 14);
		send_directed(1000, 1000, 1007, 1003);
		send_directed(COORD_MAX, 0, 2000, 30);
		send_directed(20, 40, 64, 0);
		send_directed(2040, 2040, COORD_MAX, COORD_MAX);
	endtask

	// Wait for every expected pixel, then let in-flight empty segments retire
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin : stimulus
		logic [COLOR_BITS-1:0] phase_colors[NUM_PHASES];
		sb = new();
		phase_colors[0] = '1;
		phase_colors[1] = '0;
		phase_colors[2] = $urandom;
		phase_colors[3] = $urandom;
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// one color per phase; phase 2 runs with no idling on either side
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			idle_on = (phase != 2);
			write_line_color(phase_colors[phase]);
			if (phase == 0)
				run_directed();
			repeat (RANDOM_PER_PHASE)
				send_random_segment();
			drain();
		end
		$display("Covered %0d segments (%0d empty, %0d saturated) under %0d line colors,",
			sb.segments, sb.empty_segments, sb.clipped_segments, NUM_PHASES);
		$display("checked %0d pixels, %0d errors", sb.pixels_checked, sb.errors);
		if (sb.errors == 0)
			$display("dda_line_rasterizer test passed");
		else
			$display("dda_line_rasterizer test failed");
		$finish;
	end

endmodule
